### hw/rtl/beep_list_square_wave_player_assert.svh
// Assertion macros shared by the beep list player modules.
`ifndef BEEP_LIST_SQUARE_WAVE_PLAYER_ASSERT_SVH
`define BEEP_LIST_SQUARE_WAVE_PLAYER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BLSW_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define BLSW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/blsw_pkg.sv
// Shared types and constants of the beep list square wave player.
package blsw_pkg;

    // Default sizes of the beep word memory and the sound table.
    localparam int BEEP_WORDS_DEF = 4096;
    localparam int MAX_SOUNDS_DEF = 128;

    // Beep list word that ends a sound.
    localparam logic [15:0] END_WORD = 16'hFFFF;

    // Reset values of the configuration registers.
    localparam logic [7:0]  SPB_RESET   = 8'd125;
    localparam logic [15:0] RATE_RESET  = 16'd18157;
    localparam logic [20:0] TIMER_RESET = 21'd1193182;
    localparam logic [6:0]  AMP_RESET   = 7'd63;

    // Configuration register file as seen by the datapath.
    typedef struct packed {
        logic        system_disabled;
        logic        sound_muted;
        logic [7:0]  sound_count;
        logic [7:0]  samples_per_beep;
        logic [15:0] sample_rate;
        logic [20:0] timer_rate;
        logic [6:0]  amplitude;
    } cfg_t;

    // Command handed from the sequencer stage to the wave stage.
    typedef struct packed {
        logic [31:0] product;
        logic        arm;
        logic        wave_en;
        logic        playing;
        logic [6:0]  current_sound;
        logic        ended;
        logic        accepted;
    } wave_cmd_t;

endpackage

### hw/rtl/blsw_intf.sv
// Channel interfaces of the beep list square wave player.

// Request channel.
interface blsw_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic [7:0]  sound_number;
    logic [11:0] beep_addr;
    logic [15:0] beep_word;
    logic [6:0]  entry_index;
    logic [11:0] entry_start;
    logic [7:0]  entry_priority;
    logic        entry_valid;

    modport source (
        output valid, req_type, sound_number, beep_addr, beep_word,
               entry_index, entry_start, entry_priority, entry_valid,
        input  ready
    );
    modport sink (
        input  valid, req_type, sound_number, beep_addr, beep_word,
               entry_index, entry_start, entry_priority, entry_valid,
        output ready
    );
endinterface

// Result channel.
interface blsw_rsp_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] sample;
    logic              playing;
    logic [6:0]        current_sound;
    logic              sound_ended;
    logic              start_accepted;

    modport source (
        output valid, sample, playing, current_sound, sound_ended, start_accepted,
        input  ready
    );
    modport sink (
        input  valid, sample, playing, current_sound, sound_ended, start_accepted,
        output ready
    );
endinterface

// Configuration write channel.
interface blsw_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [20:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

### hw/rtl/blsw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module blsw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### hw/rtl/blsw_seq.sv
// Request sequencer: memories, sound table, gates and list pointer state.
`include "beep_list_square_wave_player_assert.svh"

module blsw_seq #(
    parameter int BEEP_WORDS = blsw_pkg::BEEP_WORDS_DEF,
    parameter int MAX_SOUNDS = blsw_pkg::MAX_SOUNDS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    blsw_req_if.sink            req,
    input  blsw_pkg::cfg_t      cfg,
    output logic                cmd_valid,
    input  logic                cmd_ready,
    output blsw_pkg::wave_cmd_t cmd
);

    localparam int PTR_W = $clog2(BEEP_WORDS);
    localparam int SND_W = (MAX_SOUNDS > 1) ? $clog2(MAX_SOUNDS) : 1;
    localparam int ENT_W = PTR_W + 8;

    typedef enum logic [2:0] {
        REQ_TICK     = 3'd0,
        REQ_START    = 3'd1,
        REQ_STOP     = 3'd2,
        REQ_BEEP_WR  = 3'd3,
        REQ_ENTRY_WR = 3'd4
    } req_code_e;

    // Reduce a 12-bit start address modulo the memory size.
    function automatic logic [PTR_W-1:0] start_mod(input logic [11:0] v);
        logic [19:0] r;
        r = 20'(v);
        for (int k = 3; k >= 0; k--)
        begin
            if (r >= (20'(BEEP_WORDS) << k))
            begin
                r = r - (20'(BEEP_WORDS) << k);
            end
        end
        return PTR_W'(r);
    endfunction

    logic                  s1_valid_reg;
    logic [2:0]            s1_type_reg;
    logic [7:0]            s1_num_reg;
    logic                  gen_reg, gen_next;
    logic [PTR_W-1:0]      ptr_reg, ptr_next;
    logic [7:0]            left_reg, left_next;
    logic                  active_reg, active_next;
    logic [6:0]            aidx_reg, aidx_next;
    logic [7:0]            limit_reg, limit_next;
    logic [MAX_SOUNDS-1:0] valid_reg;

    logic             accept;
    logic             s1_go;
    logic             armed;
    logic [PTR_W-1:0] ptr_inc;
    logic [PTR_W-1:0] ptr_rd;
    logic             beep_we;
    logic             beep_re;
    logic [15:0]      word;
    logic             ent_we;
    logic             ent_re;
    logic [7:0]       idx_in;
    logic [ENT_W-1:0] ent_rdata;
    logic [7:0]       s1_idx;
    logic [8:0]       count_lim;
    logic             in_range;
    logic             ent_valid;
    logic [PTR_W-1:0] ent_start;
    logic [7:0]       ent_prio;
    logic             start_ok;
    logic [7:0]       beep_len;
    logic [7:0]       left_base;
    logic             word_end;
    logic             cmd_arm, cmd_wave, cmd_ended, cmd_acc;

    // One item sits in the first stage at a time.
    assign req.ready = !s1_valid_reg;
    assign accept    = req.valid && req.ready;
    assign s1_go     = s1_valid_reg && cmd_ready;
    assign cmd_valid = s1_valid_reg;

    // Address of the word the next tick plays.
    assign armed   = (left_reg == 8'd0);
    assign ptr_inc = (ptr_reg == PTR_W'(BEEP_WORDS - 1)) ? '0 : ptr_reg + 1'b1;
    assign ptr_rd  = armed ? ptr_inc : ptr_reg;

    // Beep word memory: writes and tick reads at transfer time.
    assign beep_we = accept && (req.req_type == REQ_BEEP_WR)
                     && ({20'd0, req.beep_addr} < 32'(BEEP_WORDS));
    assign beep_re = accept && (req.req_type == REQ_TICK);

    blsw_ram #(
        .WIDTH (16),
        .DEPTH (BEEP_WORDS)
    ) u_beep_ram (
        .clk     (clk),
        .wr_en   (beep_we),
        .wr_addr (PTR_W'(req.beep_addr)),
        .wr_data (req.beep_word),
        .rd_en   (beep_re),
        .rd_addr (ptr_rd),
        .rd_data (word)
    );

    // Sound table memory holds start address and priority of each entry.
    assign idx_in = req.sound_number - 8'd1;
    assign ent_we = accept && (req.req_type == REQ_ENTRY_WR)
                    && ({25'd0, req.entry_index} < 32'(MAX_SOUNDS));
    assign ent_re = accept && (req.req_type == REQ_START);

    blsw_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_SOUNDS)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (ent_we),
        .wr_addr (SND_W'(req.entry_index)),
        .wr_data ({start_mod(req.entry_start), req.entry_priority}),
        .rd_en   (ent_re),
        .rd_addr (idx_in[SND_W-1:0]),
        .rd_data (ent_rdata)
    );

    // Start gates.
    assign s1_idx    = s1_num_reg - 8'd1;
    assign count_lim = ({1'b0, cfg.sound_count} > 9'(MAX_SOUNDS)) ?
                       9'(MAX_SOUNDS) : {1'b0, cfg.sound_count};
    assign in_range  = ({1'b0, s1_idx} < count_lim);
    assign ent_valid = in_range && valid_reg[s1_idx[SND_W-1:0]];
    assign ent_start = ent_rdata[ENT_W-1:8];
    assign ent_prio  = ent_rdata[7:0];
    assign start_ok  = !cfg.system_disabled && !cfg.sound_muted
                       && (s1_num_reg != 8'd0) && ent_valid
                       && !(active_reg && (ent_prio < limit_reg));

    // Word length and end detection.
    assign beep_len  = (cfg.samples_per_beep == 8'd0) ? 8'd1 : cfg.samples_per_beep;
    assign left_base = armed ? beep_len : left_reg;
    assign word_end  = (word == blsw_pkg::END_WORD);

    // Next sequencer state for the item in the first stage.
    always_comb
    begin
        gen_next    = gen_reg;
        ptr_next    = ptr_reg;
        left_next   = left_reg;
        active_next = active_reg;
        aidx_next   = aidx_reg;
        limit_next  = limit_reg;
        cmd_arm     = 1'b0;
        cmd_wave    = 1'b0;
        cmd_ended   = 1'b0;
        cmd_acc     = 1'b0;
        unique case (s1_type_reg)
            REQ_TICK:
            begin
                if (gen_reg)
                begin
                    ptr_next = ptr_rd;
                    cmd_arm  = armed;
                    if (word_end)
                    begin
                        gen_next    = 1'b0;
                        active_next = 1'b0;
                        limit_next  = 8'd0;
                        left_next   = left_base;
                        cmd_ended   = 1'b1;
                    end
                    else
                    begin
                        left_next = left_base - 8'd1;
                        cmd_wave  = (word != 16'd0);
                    end
                end
            end
            REQ_START:
            begin
                if (start_ok)
                begin
                    active_next = 1'b1;
                    aidx_next   = s1_idx[6:0];
                    limit_next  = ent_prio;
                    gen_next    = 1'b1;
                    ptr_next    = ent_start;
                    left_next   = beep_len;
                    cmd_arm     = 1'b1;
                    cmd_acc     = 1'b1;
                end
            end
            REQ_STOP:
            begin
                if (!cfg.system_disabled)
                begin
                    gen_next = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Command to the wave stage; threshold product is formed here.
    always_comb
    begin
        cmd.product       = 32'(cfg.sample_rate) * 32'(word);
        cmd.arm           = cmd_arm;
        cmd.wave_en       = cmd_wave;
        cmd.playing       = active_next;
        cmd.current_sound = active_next ? aidx_next : 7'd0;
        cmd.ended         = cmd_ended;
        cmd.accepted      = cmd_acc;
    end

    // First stage item register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_type_reg <= req.req_type;
            s1_num_reg  <= req.sound_number;
        end
    end

    // Sequencer state commits when the item leaves the first stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_reg    <= 1'b0;
            ptr_reg    <= '0;
            left_reg   <= 8'd0;
            active_reg <= 1'b0;
            aidx_reg   <= 7'd0;
            limit_reg  <= 8'd0;
        end
        else if (s1_go)
        begin
            gen_reg    <= gen_next;
            ptr_reg    <= ptr_next;
            left_reg   <= left_next;
            active_reg <= active_next;
            aidx_reg   <= aidx_next;
            limit_reg  <= limit_next;
        end
    end

    // Entry valid marks, cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < MAX_SOUNDS; i++)
            begin
                if (ent_we && (8'(i) == {1'b0, req.entry_index}))
                begin
                    valid_reg[i] <= req.entry_valid;
                end
            end
        end
    end

    // Generation only runs for a sound that is marked active.
    `BLSW_ASSERT_IMPLIES(a_gen_active, gen_reg, active_reg,
        "generating without an active sound")
    // The priority limiter is clear whenever no sound is active.
    `BLSW_ASSERT_IMPLIES(a_idle_limit, !active_reg, limit_reg == 8'd0,
        "priority limiter set with no active sound")
    // A stalled first stage keeps its item.
    `BLSW_ASSERT_NEXT(a_s1_hold, s1_valid_reg && !cmd_ready,
        s1_valid_reg && $stable(s1_type_reg),
        "first stage item lost during stall")

endmodule

### hw/rtl/blsw_wave.sv
// Wave stage: phase accumulator, sample forming and result register.
`include "beep_list_square_wave_player_assert.svh"

module blsw_wave (
    input  logic                clk,
    input  logic                rst_n,
    input  blsw_pkg::cfg_t      cfg,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  blsw_pkg::wave_cmd_t cmd,
    blsw_rsp_if.source          rsp
);

    logic                s2_valid_reg;
    blsw_pkg::wave_cmd_t s2_cmd_reg;
    logic [33:0]         acc_reg, acc_next;
    logic                neg_reg, neg_next;
    logic                out_valid_reg;
    logic signed [7:0]   out_sample_reg, sample_next;
    logic                out_playing_reg;
    logic [6:0]          out_sound_reg;
    logic                out_ended_reg;
    logic                out_acc_reg;

    logic        s2_go;
    logic [33:0] base_acc;
    logic        base_neg;
    logic [33:0] sum;
    logic [34:0] diff;
    logic [7:0]  amp8;

    // The wave stage moves when the result register is free or drains.
    assign s2_go     = s2_valid_reg && (!out_valid_reg || rsp.ready);
    assign cmd_ready = !s2_valid_reg || s2_go;

    // Accumulator step with a single threshold subtraction.
    assign base_acc = s2_cmd_reg.arm ? 34'd0 : acc_reg;
    assign base_neg = s2_cmd_reg.arm ? 1'b0 : neg_reg;
    assign sum      = base_acc + {12'd0, cfg.timer_rate, 1'b0};
    assign diff     = {1'b0, sum} - {3'd0, s2_cmd_reg.product};
    assign amp8     = {1'b0, cfg.amplitude};

    always_comb
    begin
        acc_next    = base_acc;
        neg_next    = base_neg;
        sample_next = 8'sd0;
        if (s2_cmd_reg.wave_en)
        begin
            sample_next = base_neg ? signed'(8'd0 - amp8) : signed'(amp8);
            if (!diff[34])
            begin
                acc_next = diff[33:0];
                neg_next = !base_neg;
            end
            else
            begin
                acc_next = sum;
            end
        end
    end

    // Second stage command register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (cmd_ready)
        begin
            s2_valid_reg <= cmd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_ready && cmd_valid)
        begin
            s2_cmd_reg <= cmd;
        end
    end

    // Wave state and result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= 34'd0;
            neg_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (s2_go)
        begin
            acc_reg       <= acc_next;
            neg_reg       <= neg_next;
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (s2_go)
        begin
            out_sample_reg  <= sample_next;
            out_playing_reg <= s2_cmd_reg.playing;
            out_sound_reg   <= s2_cmd_reg.current_sound;
            out_ended_reg   <= s2_cmd_reg.ended;
            out_acc_reg     <= s2_cmd_reg.accepted;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.sample         = out_sample_reg;
    assign rsp.playing        = out_playing_reg;
    assign rsp.current_sound  = out_sound_reg;
    assign rsp.sound_ended    = out_ended_reg;
    assign rsp.start_accepted = out_acc_reg;

    // The end of a sound produces silence.
    `BLSW_ASSERT_IMPLIES(a_end_silent, out_valid_reg && out_ended_reg,
        out_sample_reg == 8'sd0, "nonzero sample on end of sound")
    // An accepted start always reports a playing sound.
    `BLSW_ASSERT_IMPLIES(a_start_playing, out_valid_reg && out_acc_reg,
        out_playing_reg, "accepted start without playing flag")
    // A stalled wave stage keeps its command.
    `BLSW_ASSERT_NEXT(a_s2_hold, s2_valid_reg && !s2_go, s2_valid_reg,
        "wave stage command lost during stall")

endmodule

### hw/rtl/beep_list_square_wave_player.sv
// Top level of the beep list square wave player: configuration and stage wiring.
//
//  Channel   Role    Carries
//  req       sink    tick, start, stop, beep word write, sound entry write
//  rsp       source  sample, playing, current_sound, sound_ended, start_accepted
//  cfg       sink    register index and write data, always ready
//
// An item is registered in the first stage, the second stage and the result
// register. The sequencer stage takes no new request while it holds an item,
// set by the read-modify-write of the list pointer state around the registered
// beep memory read. Reset clears control state and the entry valid marks; the
// memories are not cleared. A stalled result holds the wave stage, then the
// sequencer stage, and req.ready drops while the sequencer stage is occupied.
module beep_list_square_wave_player #(
    parameter int BEEP_WORDS = blsw_pkg::BEEP_WORDS_DEF,
    parameter int MAX_SOUNDS = blsw_pkg::MAX_SOUNDS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    blsw_req_if.sink   req,
    blsw_rsp_if.source rsp,
    blsw_cfg_if.sink   cfg
);

    typedef enum logic [2:0] {
        CFG_SYS_DISABLED = 3'd0,
        CFG_SOUND_MUTED  = 3'd1,
        CFG_SOUND_COUNT  = 3'd2,
        CFG_SPB          = 3'd3,
        CFG_SAMPLE_RATE  = 3'd4,
        CFG_TIMER_RATE   = 3'd5,
        CFG_AMPLITUDE    = 3'd6
    } cfg_idx_e;

    blsw_pkg::cfg_t      cfg_reg;
    logic                cmd_valid;
    logic                cmd_ready;
    blsw_pkg::wave_cmd_t cmd;

    assign cfg.ready = 1'b1;

    // Configuration register file.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.system_disabled  <= 1'b0;
            cfg_reg.sound_muted      <= 1'b0;
            cfg_reg.sound_count      <= 8'd0;
            cfg_reg.samples_per_beep <= blsw_pkg::SPB_RESET;
            cfg_reg.sample_rate      <= blsw_pkg::RATE_RESET;
            cfg_reg.timer_rate       <= blsw_pkg::TIMER_RESET;
            cfg_reg.amplitude        <= blsw_pkg::AMP_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                CFG_SYS_DISABLED: cfg_reg.system_disabled  <= cfg.data[0];
                CFG_SOUND_MUTED:  cfg_reg.sound_muted      <= cfg.data[0];
                CFG_SOUND_COUNT:  cfg_reg.sound_count      <= cfg.data[7:0];
                CFG_SPB:          cfg_reg.samples_per_beep <= cfg.data[7:0];
                CFG_SAMPLE_RATE:  cfg_reg.sample_rate      <= cfg.data[15:0];
                CFG_TIMER_RATE:   cfg_reg.timer_rate       <= cfg.data;
                CFG_AMPLITUDE:    cfg_reg.amplitude        <= cfg.data[6:0];
                default:
                begin
                end
            endcase
        end
    end

    // Sequencer stage with the beep memory and sound table.
    blsw_seq #(
        .BEEP_WORDS (BEEP_WORDS),
        .MAX_SOUNDS (MAX_SOUNDS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg       (cfg_reg),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    // Wave stage and result register.
    blsw_wave u_wave (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp       (rsp)
    );

endmodule

### bench/tb.sv
// Self-checking bench for the beep list square wave player, with its own prediction of the block.
`timescale 1ns / 100ps

module tb;

    localparam int BEEP_WORDS   = blsw_pkg::BEEP_WORDS_DEF;
    localparam int MAX_SOUNDS   = blsw_pkg::MAX_SOUNDS_DEF;
    localparam int ITEM_TARGET  = 1800;
    localparam int PHASE_ITEMS  = 150;
    localparam int DRAIN_CYCLES = 4;
    localparam int TAIL_CYCLES  = 8;
    localparam int STALL_LIMIT  = 2000;

    typedef enum logic [2:0] {
        REQ_TICK, REQ_START, REQ_STOP, REQ_WRITE_WORD, REQ_WRITE_ENTRY,
        REQ_SPARE5, REQ_SPARE6, REQ_SPARE7
    } req_kind_e;

    typedef enum logic [2:0] {
        REG_SYSTEM_DISABLED, REG_SOUND_MUTED, REG_SOUND_COUNT, REG_SAMPLES_PER_BEEP,
        REG_SAMPLE_RATE, REG_TIMER_RATE, REG_AMPLITUDE
    } reg_index_e;

    typedef struct packed {
        req_kind_e   kind;
        logic [7:0]  number;
        logic [11:0] addr;
        logic [15:0] word;
        logic [6:0]  ent;
        logic [11:0] start;
        logic [7:0]  prio;
        logic        mark;
    } play_req_t;

    typedef struct packed {
        logic signed [7:0] sample;
        logic              playing;
        logic [6:0]        sound;
        logic              ended;
        logic              accepted;
    } play_out_t;

    typedef struct {
        bit          is_reg;
        reg_index_e  reg_sel;
        logic [20:0] reg_value;
        play_req_t   rq;
        bit          fixed;
        play_out_t   want;
    } script_row_t;

    logic clk;
    logic rst_n;

    blsw_req_if req_ch ();
    blsw_rsp_if rsp_ch ();
    blsw_cfg_if cfg_ch ();

    beep_list_square_wave_player dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // Shadow copy of the player: register file, memories and playback state.
    blsw_pkg::cfg_t settings;
    logic [15:0] beep_mem [BEEP_WORDS];
    bit          word_written [BEEP_WORDS];
    logic [11:0] entry_base [MAX_SOUNDS];
    logic [7:0]  entry_rank [MAX_SOUNDS];
    bit          entry_live [MAX_SOUNDS];
    bit          generating;
    bit          wave_neg;
    bit          active;
    logic [11:0] ptr;
    logic [15:0] cur_word;
    logic [7:0]  left;
    logic [33:0] phase_acc;
    logic [6:0]  active_slot;
    logic [7:0]  limiter;

    play_out_t   due_results [$];
    script_row_t script [$];
    int          mismatches;
    int          items_sent;
    int          quiet_cycles;
    bit          steady_run;

    // Clock generation.
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic void reset_player();
        settings = '0;
        settings.samples_per_beep = blsw_pkg::SPB_RESET;
        settings.sample_rate = blsw_pkg::RATE_RESET;
        settings.timer_rate = blsw_pkg::TIMER_RESET;
        settings.amplitude = blsw_pkg::AMP_RESET;
        foreach (word_written[i]) word_written[i] = 1'b0;
        foreach (entry_live[i]) entry_live[i] = 1'b0;
        generating = 1'b0;
        wave_neg = 1'b0;
        active = 1'b0;
        ptr = '0;
        cur_word = '0;
        left = '0;
        phase_acc = '0;
        active_slot = '0;
        limiter = '0;
    endfunction

    function automatic void apply_reg(reg_index_e i, logic [20:0] d);
        case (i)
            REG_SYSTEM_DISABLED:  settings.system_disabled = d[0];
            REG_SOUND_MUTED:      settings.sound_muted = d[0];
            REG_SOUND_COUNT:      settings.sound_count = d[7:0];
            REG_SAMPLES_PER_BEEP: settings.samples_per_beep = d[7:0];
            REG_SAMPLE_RATE:      settings.sample_rate = d[15:0];
            REG_TIMER_RATE:       settings.timer_rate = d[20:0];
            REG_AMPLITUDE:        settings.amplitude = d[6:0];
            default: ;
        endcase
    endfunction

    function automatic logic [7:0] beep_length();
        return (settings.samples_per_beep == 8'd0) ? 8'd1 : settings.samples_per_beep;
    endfunction

    // Applies one request to the shadow state and returns the result it produces.
    function automatic play_out_t advance_player(play_req_t r);
        play_out_t   o;
        logic [31:0] thr;
        logic [7:0]  slot;
        int          lim;
        o = '0;
        case (r.kind)
            REQ_TICK:
                if (generating)
                begin
                    // A spent word moves the pointer on and restarts the wave.
                    if (left == 8'd0)
                    begin
                        ptr = ptr + 12'd1;
                        left = beep_length();
                        phase_acc = '0;
                        wave_neg = 1'b0;
                    end
                    cur_word = beep_mem[ptr];
                    if (cur_word == blsw_pkg::END_WORD)
                    begin
                        generating = 1'b0;
                        active = 1'b0;
                        limiter = '0;
                        o.ended = 1'b1;
                    end
                    else
                    begin
                        if (cur_word != 16'd0)
                        begin
                            thr = 32'(settings.sample_rate) * 32'(cur_word);
                            o.sample = wave_neg ? -$signed({1'b0, settings.amplitude})
                                                : $signed({1'b0, settings.amplitude});
                            phase_acc = phase_acc + {12'd0, settings.timer_rate, 1'b0};
                            if (phase_acc >= {2'b00, thr})
                            begin
                                phase_acc = phase_acc - {2'b00, thr};
                                wave_neg = !wave_neg;
                            end
                        end
                        left = left - 8'd1;
                    end
                end
            REQ_START:
                if (!settings.system_disabled && !settings.sound_muted && r.number != 8'd0)
                begin
                    slot = r.number - 8'd1;
                    lim = (int'(settings.sound_count) > MAX_SOUNDS) ? MAX_SOUNDS
                                                                     : int'(settings.sound_count);
                    // The priority gate applies only while a sound is marked active.
                    if (int'(slot) < lim && entry_live[slot[6:0]] &&
                        !(active && entry_rank[slot[6:0]] < limiter))
                    begin
                        active = 1'b1;
                        active_slot = slot[6:0];
                        limiter = entry_rank[slot[6:0]];
                        generating = 1'b1;
                        ptr = entry_base[slot[6:0]];
                        left = beep_length();
                        phase_acc = '0;
                        wave_neg = 1'b0;
                        o.accepted = 1'b1;
                    end
                end
            REQ_STOP:
                if (!settings.system_disabled)
                    generating = 1'b0;
            REQ_WRITE_WORD:
            begin
                beep_mem[r.addr] = r.word;
                word_written[r.addr] = 1'b1;
            end
            REQ_WRITE_ENTRY:
            begin
                entry_base[r.ent] = r.start;
                entry_rank[r.ent] = r.prio;
                entry_live[r.ent] = r.mark;
            end
            default: ;
        endcase
        o.playing = active;
        o.sound = active ? active_slot : 7'd0;
        return o;
    endfunction

    // Finds whether the next tick would read a beep word that was never written.
    function automatic bit tick_hits_blank(output logic [11:0] a);
        a = (left == 8'd0) ? ptr + 12'd1 : ptr;
        return generating && !word_written[a];
    endfunction

    function automatic play_req_t random_req();
        play_req_t r;
        r.kind = req_kind_e'($urandom_range(0, 7));
        r.number = 8'($urandom_range(0, 255));
        r.addr = 12'($urandom_range(0, 4095));
        r.word = 16'($urandom_range(0, 65535));
        r.ent = 7'($urandom_range(0, 127));
        r.start = 12'($urandom_range(0, 4095));
        r.prio = 8'($urandom_range(0, 255));
        r.mark = 1'($urandom_range(0, 1));
        return r;
    endfunction

    function automatic play_req_t tick_req();
        play_req_t r;
        r = random_req();
        r.kind = REQ_TICK;
        return r;
    endfunction

    function automatic play_req_t start_req(int n);
        play_req_t r;
        r = random_req();
        r.kind = REQ_START;
        r.number = 8'(n);
        return r;
    endfunction

    function automatic play_req_t plain_req(req_kind_e k);
        play_req_t r;
        r = random_req();
        r.kind = k;
        return r;
    endfunction

    function automatic play_req_t word_req(int a, int w);
        play_req_t r;
        r = random_req();
        r.kind = REQ_WRITE_WORD;
        r.addr = 12'(a);
        r.word = 16'(w);
        return r;
    endfunction

    function automatic play_req_t entry_req(int e, int s, int p, bit m);
        play_req_t r;
        r = random_req();
        r.kind = REQ_WRITE_ENTRY;
        r.ent = 7'(e);
        r.start = 12'(s);
        r.prio = 8'(p);
        r.mark = m;
        return r;
    endfunction

    function automatic play_out_t outcome(int smp, bit pl, int snd, bit en, bit acc);
        play_out_t o;
        o.sample = 8'(smp);
        o.playing = pl;
        o.sound = 7'(snd);
        o.ended = en;
        o.accepted = acc;
        return o;
    endfunction

    // Builds an empty script row.
    function automatic script_row_t blank_row();
        script_row_t row;
        row.is_reg = 1'b0;
        row.reg_sel = REG_SYSTEM_DISABLED;
        row.reg_value = '0;
        row.rq = '0;
        row.fixed = 1'b0;
        row.want = '0;
        return row;
    endfunction

    function automatic void add_checked(play_req_t r);
        script_row_t row;
        row = blank_row();
        row.rq = r;
        script.push_back(row);
    endfunction

    function automatic void add_typed(play_req_t r, play_out_t want);
        script_row_t row;
        row = blank_row();
        row.rq = r;
        row.fixed = 1'b1;
        row.want = want;
        script.push_back(row);
    endfunction

    function automatic void add_reg(reg_index_e i, int d);
        script_row_t row;
        row = blank_row();
        row.is_reg = 1'b1;
        row.reg_sel = i;
        row.reg_value = 21'(d);
        script.push_back(row);
    endfunction

    task automatic note_mismatch(string what, play_out_t want, play_out_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s: expected sample %0d playing %0b sound %0d ended %0b accepted %0b",
                     $realtime, what, $signed(want.sample), want.playing, want.sound,
                     want.ended, want.accepted,
                     "; got sample %0d playing %0b sound %0d ended %0b accepted %0b",
                     $signed(got.sample), got.playing, got.sound, got.ended, got.accepted);
    endtask

    // Drives one request from a falling edge and records its result once transferred.
    task automatic issue(play_req_t r, bit fixed, play_out_t want);
        play_out_t got;
        while (!steady_run && $urandom_range(0, 99) < 8)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.req_type <= r.kind;
        req_ch.sound_number <= r.number;
        req_ch.beep_addr <= r.addr;
        req_ch.beep_word <= r.word;
        req_ch.entry_index <= r.ent;
        req_ch.entry_start <= r.start;
        req_ch.entry_priority <= r.prio;
        req_ch.entry_valid <= r.mark;
        do
            @(posedge clk);
        while (!req_ch.ready);
        @(negedge clk);
        got = advance_player(r);
        due_results.push_back(fixed ? want : got);
        items_sent++;
    endtask

    // A tick that would read a blank beep word gets that word written first.
    task automatic send(play_req_t r, bit fixed, play_out_t want);
        logic [11:0] a;
        if (r.kind == REQ_TICK && tick_hits_blank(a))
            issue(word_req(a, $urandom_range(0, 1) ? int'(blsw_pkg::END_WORD)
                                                    : $urandom_range(0, 65535)),
                  1'b0, '0);
        issue(r, fixed, want);
    endtask

    task automatic settle();
        req_ch.valid <= 1'b0;
        while (due_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(reg_index_e i, logic [20:0] d);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= i;
        cfg_ch.data <= d;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        apply_reg(i, d);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    // Directed rows: reset state, rejected starts, wrap, end marker, stop and the limiter.
    task automatic run_script();
        add_typed(tick_req(), '0);
        add_typed(start_req(0), '0);
        add_typed(start_req(1), '0);
        add_typed(plain_req(REQ_STOP), '0);
        add_typed(plain_req(REQ_SPARE5), '0);
        add_typed(plain_req(REQ_SPARE7), '0);
        add_typed(word_req(4095, 1), '0);
        add_typed(word_req(0, 0), '0);
        add_typed(word_req(1, blsw_pkg::END_WORD), '0);
        add_typed(word_req(10, blsw_pkg::END_WORD), '0);
        add_typed(entry_req(0, 4095, 255, 1'b1), '0);
        add_typed(entry_req(127, 10, 0, 1'b1), '0);
        add_typed(entry_req(5, 0, 7, 1'b0), '0);
        add_reg(REG_SOUND_COUNT, 255);
        add_reg(REG_SAMPLES_PER_BEEP, 0);
        add_reg(REG_AMPLITUDE, 127);
        add_typed(start_req(128), outcome(0, 1, 127, 0, 1));
        add_typed(tick_req(), outcome(0, 0, 0, 1, 0));
        add_typed(start_req(6), '0);
        add_typed(start_req(1), outcome(0, 1, 0, 0, 1));
        add_typed(start_req(128), outcome(0, 1, 0, 0, 0));
        add_checked(tick_req());
        add_checked(tick_req());
        add_checked(tick_req());
        add_reg(REG_SOUND_MUTED, 1);
        add_typed(start_req(1), '0);
        add_reg(REG_SOUND_MUTED, 0);
        add_reg(REG_SYSTEM_DISABLED, 1);
        add_typed(start_req(1), '0);
        add_reg(REG_SYSTEM_DISABLED, 0);
        add_typed(start_req(1), outcome(0, 1, 0, 0, 1));
        add_typed(plain_req(REQ_STOP), outcome(0, 1, 0, 0, 0));
        add_typed(tick_req(), outcome(0, 1, 0, 0, 0));
        add_typed(start_req(128), outcome(0, 1, 0, 0, 0));
        add_typed(start_req(1), outcome(0, 1, 0, 0, 1));
        foreach (script[i])
        begin
            if (script[i].is_reg)
            begin
                settle();
                write_reg(script[i].reg_sel, script[i].reg_value);
            end
            else
                send(script[i].rq, script[i].fixed, script[i].want);
        end
    endtask

    // Register settings for one phase; two phases take the extremes of samples_per_beep.
    task automatic random_setup(int ph);
        logic [20:0] v;
        write_reg(REG_SYSTEM_DISABLED, 21'($urandom_range(0, 5) == 0));
        write_reg(REG_SOUND_MUTED, 21'($urandom_range(0, 5) == 0));
        case ($urandom_range(0, 7))
            0:       v = 21'd0;
            1:       v = 21'd1;
            2, 3:    v = 21'd128;
            4:       v = 21'd255;
            default: v = 21'($urandom_range(2, 127));
        endcase
        write_reg(REG_SOUND_COUNT, v);
        if (ph == 1)
            v = 21'd255;
        else if (ph == 4)
            v = 21'd0;
        else
            v = 21'($urandom_range(1, 6));
        write_reg(REG_SAMPLES_PER_BEEP, v);
        case ($urandom_range(0, 3))
            0:       v = 21'd1;
            1:       v = 21'd65535;
            2:       v = 21'(blsw_pkg::RATE_RESET);
            default: v = 21'($urandom_range(1, 65535));
        endcase
        write_reg(REG_SAMPLE_RATE, v);
        case ($urandom_range(0, 3))
            0:       v = 21'd1;
            1:       v = 21'd2097151;
            2:       v = blsw_pkg::TIMER_RESET;
            default: v = 21'($urandom_range(1, 2097151));
        endcase
        write_reg(REG_TIMER_RATE, v);
        case ($urandom_range(0, 3))
            0:       v = 21'd0;
            1:       v = 21'd127;
            default: v = 21'($urandom_range(1, 126));
        endcase
        write_reg(REG_AMPLITUDE, v);
    endtask

    function automatic int pick_period();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return $urandom_range(1, 16);
            2:       return $urandom_range(17, 400);
            3:       return 16'hFFFE;
            default: return $urandom_range(1, 16'hFFFE);
        endcase
    endfunction

    task automatic send_noise();
        play_req_t r;
        r = random_req();
        case ($urandom_range(0, 9))
            0, 1, 8: r.kind = REQ_TICK;
            2, 3:    r.kind = REQ_START;
            4:       r.kind = REQ_STOP;
            5:       r.kind = REQ_WRITE_WORD;
            6:       r.kind = REQ_WRITE_ENTRY;
            7:       r.kind = req_kind_e'($urandom_range(5, 7));
            default: r.kind = REQ_TICK;
        endcase
        send(r, 1'b0, '0);
    endtask

    // A well-formed sound: list words, end marker, table entry, start, then ticks.
    task automatic play_sequence();
        logic [11:0] base;
        int          len;
        int          slot;
        int          lim;
        int          ticks;
        len = $urandom_range(1, 5);
        base = ($urandom_range(0, 7) == 0) ? 12'(4095 - $urandom_range(0, 3))
                                           : 12'($urandom_range(0, 4095));
        for (int i = 0; i < len; i++)
            send(word_req(int'(base) + i, pick_period()), 1'b0, '0);
        send(word_req(int'(base) + len, blsw_pkg::END_WORD), 1'b0, '0);
        lim = (int'(settings.sound_count) > MAX_SOUNDS) ? MAX_SOUNDS
                                                         : int'(settings.sound_count);
        slot = (lim > 0 && $urandom_range(0, 4) != 0) ? $urandom_range(0, lim - 1)
                                                      : $urandom_range(0, MAX_SOUNDS - 1);
        send(entry_req(slot, base, $urandom_range(0, 255), $urandom_range(0, 7) != 0),
             1'b0, '0);
        send(start_req(slot + 1), 1'b0, '0);
        ticks = $urandom_range(1, (len + 1) * int'(beep_length()) + 2);
        if (ticks > 300)
            ticks = 300;
        for (int i = 0; i < ticks; i++)
        begin
            if ($urandom_range(0, 19) == 0)
                send_noise();
            else
                send(tick_req(), 1'b0, '0);
        end
    endtask

    task automatic run_phase();
        int stop_at;
        stop_at = items_sent + PHASE_ITEMS;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(0, 9) < 7)
                play_sequence();
            else
                send_noise();
        end
    endtask

    // Result side: random backpressure, none during the steady stretch.
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_ch.ready <= steady_run || ($urandom_range(0, 99) >= 8);
        end
    end

    // Each result transfer is checked against the oldest expectation.
    always @(posedge clk)
    begin
        play_out_t got;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got.sample = rsp_ch.sample;
            got.playing = rsp_ch.playing;
            got.sound = rsp_ch.current_sound;
            got.ended = rsp_ch.sound_ended;
            got.accepted = rsp_ch.start_accepted;
            if (due_results.size() == 0)
                note_mismatch("result with nothing expected", '0, got);
            else if (got !== due_results[0])
                note_mismatch("result differs", due_results.pop_front(), got);
            else
                void'(due_results.pop_front());
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Main sequence: reset, directed rows, random phases, drain.
    initial
    begin
        int ph;
        rst_n = 1'b0;
        steady_run = 1'b0;
        mismatches = 0;
        items_sent = 0;
        quiet_cycles = 0;
        req_ch.valid = 1'b0;
        req_ch.req_type = REQ_TICK;
        req_ch.sound_number = '0;
        req_ch.beep_addr = '0;
        req_ch.beep_word = '0;
        req_ch.entry_index = '0;
        req_ch.entry_start = '0;
        req_ch.entry_priority = '0;
        req_ch.entry_valid = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_SYSTEM_DISABLED;
        cfg_ch.data = '0;
        reset_player();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        run_script();
        ph = 0;
        while (items_sent < ITEM_TARGET)
        begin
            settle();
            steady_run = (ph == 2 || ph == 3);
            random_setup(ph);
            run_phase();
            ph++;
        end
        settle();
        steady_run = 1'b0;
        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatches == 0 && due_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### beep_list_square_wave_player.f
+incdir+hw/rtl
hw/rtl/blsw_pkg.sv
hw/rtl/blsw_intf.sv
hw/rtl/blsw_ram.sv
hw/rtl/blsw_seq.sv
hw/rtl/blsw_wave.sv
hw/rtl/beep_list_square_wave_player.sv
bench/tb.sv
